### sv/uart8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uart8_pkg;

    localparam int DATA_BITS = 8;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int PERIOD_W  = 16;
    localparam int RX_TMR_W  = 17;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd1667;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_STOP  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic line;
        logic busy;
    } tx_status_t;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] data;
    } rx_result_t;

endpackage

`default_nettype wire

### sv/uart8_tx.sv
`timescale 1ns / 1ps
`default_nettype none

module uart8_tx (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step_en,
    input  wire logic [uart8_pkg::PERIOD_W-1:0]  bit_period,
    input  wire logic                            send_request,
    input  wire logic [uart8_pkg::BYTE_W-1:0]    send_byte,
    output uart8_pkg::tx_status_t                status_next
);
    import uart8_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PERIOD_W-1:0] timer_reg, timer_next;
    logic                line_reg, line_next;
    logic                fire;

    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        timer_next = timer_reg;
        line_next  = line_reg;
        fire       = 1'b0;
        if (phase_reg == PH_IDLE) begin
            if (send_request) begin
                shift_next = send_byte;
                count_next = '0;
                timer_next = bit_period;
                phase_next = PH_START;
            end
        end else begin
            // The bit timer fires when it has run down to one (or was loaded with zero).
            if (timer_reg <= 16'd1) begin
                timer_next = bit_period;
                fire       = 1'b1;
            end else begin
                timer_next = timer_reg - 16'd1;
            end
            if (fire) begin
                case (phase_reg)
                    PH_START: begin
                        line_next  = 1'b0;
                        phase_next = PH_DATA;
                    end
                    PH_DATA: begin
                        line_next  = shift_reg[0];
                        shift_next = {1'b0, shift_reg[BYTE_W-1:1]};
                        count_next = count_reg + 4'd1;
                        if (count_next >= CNT_W'(DATA_BITS)) begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        line_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            count_reg <= '0;
            timer_reg <= '0;
            line_reg  <= 1'b1;
        end else if (step_en) begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
            line_reg  <= line_next;
        end
    end

    assign status_next.line = line_next;
    assign status_next.busy = (phase_next != PH_IDLE);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DATA_BITS))
        else $error("tx bit count ran past the frame length");
    a_idle_line_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> line_reg)
        else $error("tx line low while idle");
    a_start_holds_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_START) |-> line_reg)
        else $error("tx line dropped before the start bit");
`endif

endmodule

`default_nettype wire

### sv/uart8_rx.sv
`timescale 1ns / 1ps
`default_nettype none

module uart8_rx (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step_en,
    input  wire logic [uart8_pkg::PERIOD_W-1:0]  bit_period,
    input  wire logic                            rx_level,
    output uart8_pkg::rx_result_t                result_next
);
    import uart8_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RX_TMR_W-1:0] timer_reg, timer_next;
    logic                prev_reg;
    logic                fire;

    always_comb begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        fire        = 1'b0;
        result_next = '0;
        if (phase_reg == PH_IDLE) begin
            if (prev_reg && !rx_level) begin
                phase_next = PH_DATA;
                count_next = '0;
                shift_next = '0;
                // First sample lands in the middle of data bit zero.
                timer_next = {1'b0, bit_period} + {2'b00, bit_period[PERIOD_W-1:1]};
            end
        end else begin
            if (timer_reg <= 17'd1) begin
                timer_next = {1'b0, bit_period};
                fire       = 1'b1;
            end else begin
                timer_next = timer_reg - 17'd1;
            end
            if (fire) begin
                case (phase_reg)
                    PH_DATA: begin
                        if (count_reg < 4'd8) begin
                            shift_next[count_reg[2:0]] = shift_reg[count_reg[2:0]] | rx_level;
                        end
                        count_next = count_reg + 4'd1;
                        if (count_next >= CNT_W'(DATA_BITS)) begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        result_next.done = 1'b1;
                        result_next.data = shift_reg;
                        phase_next       = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            count_reg <= '0;
            timer_reg <= '0;
            prev_reg  <= 1'b1;
        end else if (step_en) begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
            prev_reg  <= rx_level;
        end
    end

`ifndef ASSERT_OFF
    a_no_start_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_START)
        else $error("rx entered the transmit-only start phase");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DATA_BITS))
        else $error("rx bit count ran past the frame length");
    a_stop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STOP) |-> (count_reg == CNT_W'(DATA_BITS)))
        else $error("rx reached the stop phase with bits missing");
`endif

endmodule

`default_nettype wire

### sv/uart_8n1_transceiver.sv
`timescale 1ns / 1ps
`default_nettype none

// UART 8N1 transmitter and receiver driven one bit-timer tick per transfer: each input
// transfer is one tick of the bit timers, carrying the sampled receive line and an
// optional send request, and each produces exactly one result transfer with the
// transmit line, busy flag and any byte completed on that tick. One transfer is taken
// every cycle while the result side is not stalled; a transfer passes an input register,
// then the update of the transmit and receive state, and lands in the result register,
// where it is held until the result side takes it.
// The state update is what sets the rate. bit_period may be written only
// while no transfer is in flight.
module uart_8n1_transceiver (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [uart8_pkg::PERIOD_W-1:0]  cfg_wr_data,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire logic                            s_rx_level,
    input  wire logic                            s_send_request,
    input  wire logic [uart8_pkg::BYTE_W-1:0]    s_send_byte,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      logic                            m_tx_level,
    output      logic                            m_tx_busy,
    output      logic                            m_rx_done,
    output      logic [uart8_pkg::BYTE_W-1:0]    m_received_byte
);
    import uart8_pkg::*;

    logic [PERIOD_W-1:0] bit_period_reg;
    logic                in_valid_reg;
    logic                in_rx_level_reg;
    logic                in_send_request_reg;
    logic [BYTE_W-1:0]   in_send_byte_reg;
    logic                out_valid_reg;
    tx_status_t          tx_status_reg;
    rx_result_t          rx_result_reg;
    tx_status_t          tx_status_next;
    rx_result_t          rx_result_next;
    logic                advance;

    // The held item moves on whenever the result register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= BIT_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            bit_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_rx_level_reg     <= s_rx_level;
            in_send_request_reg <= s_send_request;
            in_send_byte_reg    <= s_send_byte;
        end
    end

    uart8_tx u_tx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .bit_period   (bit_period_reg),
        .send_request (in_send_request_reg),
        .send_byte    (in_send_byte_reg),
        .status_next  (tx_status_next)
    );

    uart8_rx u_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .bit_period  (bit_period_reg),
        .rx_level    (in_rx_level_reg),
        .result_next (rx_result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tx_status_reg <= tx_status_next;
            rx_result_reg <= rx_result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_tx_level      = tx_status_reg.line;
    assign m_tx_busy       = tx_status_reg.busy;
    assign m_rx_done       = rx_result_reg.done;
    assign m_received_byte = rx_result_reg.data;

`ifndef ASSERT_OFF
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || m_ready) |-> s_ready)
        else $error("input stalled while the result side was free");
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("a processed item produced no result");
    a_byte_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !rx_result_reg.done) |-> (rx_result_reg.data == '0))
        else $error("received byte nonzero without a completed frame");
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg)
        else $error("stalled result was lost");
`endif

endmodule

`default_nettype wire
